@@ rtl/assert_macros.svh @@
// Assertion macros for the occupancy grid block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define OGM_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("%m failed");
`define OGM_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("%m failed");
`else
`define OGM_ASSERT(label, clk, rst_n, prop)
`define OGM_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

@@ rtl/ogm_pkg.sv @@
// ----------------------------------------------------------------------------
// ogm_pkg
// Types and constants shared by the occupancy grid pass unit.
// ----------------------------------------------------------------------------
package ogm_pkg;
  localparam int unsigned MAX_DIM_DEF = 256;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 9;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_USE_REF = 2'd2;

  localparam logic [1:0] OP_WR_GRID = 2'd0;
  localparam logic [1:0] OP_WR_REF  = 2'd1;
  localparam logic [1:0] OP_RD_GRID = 2'd2;
  localparam logic [1:0] OP_PASS    = 2'd3;

  localparam logic [3:0] CLS_UNKNOWN  = 4'd0;
  localparam logic [3:0] CLS_EMPTY    = 4'd1;
  localparam logic [3:0] CLS_OCCUPIED = 4'd2;
  localparam logic [3:0] CLS_MARK     = 4'd8;

  localparam logic [2:0] PK_FREE_CLOSE = 3'd0;
  localparam logic [2:0] PK_FREE_OPEN  = 3'd1;
  localparam logic [2:0] PK_OCC_CLOSE  = 3'd2;
  localparam logic [2:0] PK_OCC_OPEN   = 3'd3;
  localparam logic [2:0] PK_OCC_GROW   = 3'd4;
  localparam logic [2:0] PK_COMP       = 3'd5;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] cell_x;
    logic [7:0] cell_y;
    logic [2:0] cell_class;
    logic [2:0] pass_kind;
  } in_req_t;

  typedef struct packed {
    logic [2:0] read_class;
    logic       pass_done;
    logic       out_of_range;
  } out_req_t;

  // per-kind rule
  typedef struct packed {
    logic [3:0] center;
    logic [3:0] target;
    logic [3:0] final_cls;
    logic       mark_center;
    logic       grow;
    logic       comp;
  } rule_t;

  function automatic rule_t kind_rule(input logic [2:0] k);
    rule_t r;
    r = '{CLS_EMPTY, CLS_UNKNOWN, CLS_OCCUPIED, 1'b0, 1'b0, 1'b1};
    case (k)
      PK_FREE_CLOSE: r = '{CLS_EMPTY, CLS_UNKNOWN, CLS_EMPTY, 1'b0, 1'b0, 1'b0};
      PK_FREE_OPEN:  r = '{CLS_EMPTY, CLS_UNKNOWN, CLS_UNKNOWN, 1'b1, 1'b0, 1'b0};
      PK_OCC_CLOSE:  r = '{CLS_OCCUPIED, CLS_EMPTY, CLS_OCCUPIED, 1'b0, 1'b0, 1'b0};
      PK_OCC_OPEN:   r = '{CLS_OCCUPIED, CLS_EMPTY, CLS_EMPTY, 1'b1, 1'b0, 1'b0};
      PK_OCC_GROW:   r = '{CLS_OCCUPIED, CLS_UNKNOWN, CLS_OCCUPIED, 1'b0, 1'b1, 1'b0};
      default:       r = '{CLS_EMPTY, CLS_UNKNOWN, CLS_OCCUPIED, 1'b0, 1'b0, 1'b1};
    endcase
    return r;
  endfunction
endpackage

@@ rtl/ogm_grid_mem.sv @@
// ----------------------------------------------------------------------------
// ogm_grid_mem
// Grid and reference memories, one port each, with registered read data.
// ----------------------------------------------------------------------------
module ogm_grid_mem #(
  parameter int unsigned AW = 16
) (
  input  logic          clk,
  input  logic          g_we,
  input  logic [AW-1:0] g_addr,
  input  logic [3:0]    g_wdata,
  output logic [3:0]    g_rdata,
  input  logic          r_we,
  input  logic [AW-1:0] r_addr,
  input  logic [2:0]    r_wdata,
  output logic [2:0]    r_rdata
);
  logic [3:0] grid_mem [2**AW];
  logic [2:0] ref_mem  [2**AW];

  always_ff @(posedge clk) begin
    if (g_we) begin
      grid_mem[g_addr] <= g_wdata;
    end
    g_rdata <= grid_mem[g_addr];
  end

  always_ff @(posedge clk) begin
    if (r_we) begin
      ref_mem[r_addr] <= r_wdata;
    end
    r_rdata <= ref_mem[r_addr];
  end
endmodule

@@ rtl/ogm_pass_ctrl.sv @@
// ----------------------------------------------------------------------------
// ogm_pass_ctrl
// Request sequencer: cell access and the read-modify-write walk of a pass.
// ----------------------------------------------------------------------------
module ogm_pass_ctrl #(
  parameter int unsigned CW = 8,
  parameter int unsigned AW = 2 * CW
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  ogm_pkg::in_req_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output ogm_pkg::out_req_t out_data,
  input  logic [CW:0]       w_use,
  input  logic [CW:0]       h_use,
  input  logic              use_ref,
  output logic              g_we,
  output logic [AW-1:0]     g_addr,
  output logic [3:0]        g_wdata,
  input  logic [3:0]        g_rdata,
  output logic              r_we,
  output logic [AW-1:0]     r_addr,
  output logic [2:0]        r_wdata,
  input  logic [2:0]        r_rdata
);
  import ogm_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RDWT  = 4'd1;
  localparam logic [3:0] S_CADR  = 4'd2;
  localparam logic [3:0] S_CCHK  = 4'd3;
  localparam logic [3:0] S_NADR  = 4'd4;
  localparam logic [3:0] S_NCHK  = 4'd5;
  localparam logic [3:0] S_NEXT  = 4'd6;
  localparam logic [3:0] S_FADR  = 4'd7;
  localparam logic [3:0] S_FCHK  = 4'd8;
  localparam logic [3:0] S_RESP  = 4'd9;

  logic [3:0]    state_r, state_nxt;
  logic [CW-1:0] x_r, x_nxt, y_r, y_nxt;
  logic [1:0]    nb_r, nb_nxt;
  logic [2:0]    kind_r, kind_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_req_t      out_data_r, out_data_nxt;
  rule_t         rule;
  logic [CW-1:0] nx, ny;
  logic          oor, last_y, last_x, hit;

  assign rule = kind_rule(kind_r);
  assign oor = ({1'b0, in_data.cell_x} >= w_use) || ({1'b0, in_data.cell_y} >= h_use);
  assign in_ready = (state_r == S_IDLE) && !out_valid_r;
  assign out_valid = out_valid_r;
  assign out_data = out_data_r;
  assign hit = (g_rdata == rule.target);

  always_comb begin
    nx = x_r;
    ny = y_r;
    case (nb_r)
      2'd0: nx = x_r - 1'b1;
      2'd1: nx = x_r + 1'b1;
      2'd2: ny = y_r - 1'b1;
      default: ny = y_r + 1'b1;
    endcase
  end

  assign last_y = ({1'b0, y_r} + 2'd2) >= h_use;
  assign last_x = ({1'b0, x_r} + 2'd2) >= w_use;

  always_comb begin
    state_nxt = state_r;
    x_nxt = x_r;
    y_nxt = y_r;
    nb_nxt = nb_r;
    kind_nxt = kind_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt = out_data_r;
    g_we = 1'b0;
    g_addr = {x_r, y_r};
    g_wdata = {1'b0, in_data.cell_class};
    r_we = 1'b0;
    r_addr = {x_r, y_r};
    r_wdata = in_data.cell_class;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          out_data_nxt = '0;
          kind_nxt = in_data.pass_kind;
          if (in_data.op == OP_PASS) begin
            if (in_data.pass_kind > PK_COMP || w_use < 3 || h_use < 3) begin
              out_data_nxt.pass_done = 1'b1;
              out_valid_nxt = 1'b1;
            end else begin
              x_nxt = CW'(1);
              y_nxt = CW'(1);
              state_nxt = S_CADR;
            end
          end else if (oor) begin
            out_data_nxt.out_of_range = 1'b1;
            out_valid_nxt = 1'b1;
          end else begin
            g_addr = {in_data.cell_x, in_data.cell_y};
            r_addr = {in_data.cell_x, in_data.cell_y};
            if (in_data.op == OP_WR_GRID) begin
              g_we = 1'b1;
              out_valid_nxt = 1'b1;
            end else if (in_data.op == OP_WR_REF) begin
              r_we = 1'b1;
              out_valid_nxt = 1'b1;
            end else begin
              state_nxt = S_RDWT;
            end
          end
        end
      end
      S_RDWT: begin
        out_data_nxt.read_class = g_rdata[2:0];
        out_valid_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      S_CADR: begin
        nb_nxt = 2'd0;
        state_nxt = S_CCHK;
      end
      S_CCHK: begin
        if (g_rdata == rule.center) begin
          g_addr = {nx, ny};
          state_nxt = S_NCHK;
        end else begin
          state_nxt = S_NEXT;
        end
      end
      S_NADR: begin
        g_addr = {nx, ny};
        state_nxt = S_NCHK;
      end
      S_NCHK: begin
        g_addr = {nx, ny};
        if (hit && rule.grow) begin
          g_we = 1'b1;
          g_wdata = CLS_MARK;
        end
        if (hit && !rule.grow) begin
          state_nxt = S_NEXT;
          if (rule.comp) begin
            g_addr = {x_r, y_r};
            g_we = 1'b1;
            g_wdata = use_ref ? {1'b0, r_rdata} : CLS_OCCUPIED;
          end else if (rule.mark_center) begin
            g_addr = {x_r, y_r};
            g_we = 1'b1;
            g_wdata = CLS_MARK;
          end else begin
            g_we = 1'b1;
            g_wdata = CLS_MARK;
          end
        end else if (nb_r == 2'd3) begin
          state_nxt = S_NEXT;
        end else begin
          nb_nxt = nb_r + 1'b1;
          state_nxt = S_NADR;
        end
      end
      S_NEXT: begin
        if (!last_y) begin
          y_nxt = y_r + 1'b1;
          state_nxt = S_CADR;
        end else if (!last_x) begin
          x_nxt = x_r + 1'b1;
          y_nxt = CW'(1);
          state_nxt = S_CADR;
        end else begin
          x_nxt = '0;
          y_nxt = '0;
          if (rule.comp) begin
            state_nxt = S_RESP;
          end else begin
            state_nxt = S_FADR;
          end
        end
      end
      S_FADR: begin
        state_nxt = S_FCHK;
      end
      S_FCHK: begin
        if (g_rdata == CLS_MARK) begin
          g_we = 1'b1;
          g_wdata = rule.final_cls;
        end
        state_nxt = S_FADR;
        if ({1'b0, y_r} + 1'b1 < h_use) begin
          y_nxt = y_r + 1'b1;
        end else if ({1'b0, x_r} + 1'b1 < w_use) begin
          x_nxt = x_r + 1'b1;
          y_nxt = '0;
        end else begin
          x_nxt = '0;
          y_nxt = '0;
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        out_data_nxt.pass_done = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      x_r <= '0;
      y_r <= '0;
      nb_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      x_r <= x_nxt;
      y_r <= y_nxt;
      nb_r <= nb_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
    out_data_r <= out_data_nxt;
  end

  `include "assert_macros.svh"
  `OGM_ASSERT(a_walk_zero_idle, clk, rst_n, (state_r == S_IDLE) |-> (x_r == '0 && y_r == '0))
  `OGM_ASSERT(a_one_flag, clk, rst_n, out_valid_r |-> $onehot0({out_data_r[1:0], |out_data_r[4:2]}))
  `OGM_ASSERT(a_no_take_busy, clk, rst_n, (state_r != S_IDLE) |-> !in_ready)
endmodule

@@ rtl/occupancy_grid_morphology_pass_unit.sv @@
// ----------------------------------------------------------------------------
// occupancy_grid_morphology_pass_unit
// Occupancy grid store with in-place morphology passes.
// ----------------------------------------------------------------------------
// Input requests (valid/ready) write a grid cell, write a reference cell,
// read a grid cell or run a pass; each gives exactly one result request.
// Cell writes, out-of-range requests and passes with nothing to walk answer
// in the cycle after acceptance; reads answer from the read wait state once
// the registered grid read returns. A pass walks the interior in a single-port
// grid memory: each cell is addressed and its class checked, and if it qualifies
// its neighbours are addressed and checked in turn; then comes a mark sweep over
// every cell in use (compensate has no sweep) and the answer.
// Input is held off while a request is in flight or a result waits, so one
// request is in the block at a time. A stalled receiver holds the result
// register and stops further acceptance. Reset clears control and sets the
// size registers to full; memory contents are undefined until written.
// Configuration writes (cfg_we) take effect at once.
// ----------------------------------------------------------------------------
module occupancy_grid_morphology_pass_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  ogm_pkg::in_req_t                in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output ogm_pkg::out_req_t               out_data,
  input  logic                            cfg_we,
  input  logic [ogm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ogm_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import ogm_pkg::*;

  localparam int unsigned CW = 8;
  localparam int unsigned AW = 2 * CW;

  logic [8:0] width_r, height_r;
  logic       use_ref_r;
  logic [CW:0] w_use, h_use;
  logic          g_we, r_we;
  logic [AW-1:0] g_addr, r_addr;
  logic [3:0]    g_wdata, g_rdata;
  logic [2:0]    r_wdata, r_rdata;

  assign w_use = (width_r > 9'(MAX_DIM_DEF)) ? 9'(MAX_DIM_DEF) : width_r;
  assign h_use = (height_r > 9'(MAX_DIM_DEF)) ? 9'(MAX_DIM_DEF) : height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= 9'd256;
      height_r <= 9'd256;
      use_ref_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WIDTH:   width_r <= cfg_data;
        CFG_HEIGHT:  height_r <= cfg_data;
        CFG_USE_REF: use_ref_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  ogm_pass_ctrl #(.CW(CW), .AW(AW)) u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data,
    .w_use, .h_use, .use_ref(use_ref_r),
    .g_we, .g_addr, .g_wdata, .g_rdata, .r_we, .r_addr, .r_wdata, .r_rdata
  );

  ogm_grid_mem #(.AW(AW)) u_mem (
    .clk, .g_we, .g_addr, .g_wdata, .g_rdata, .r_we, .r_addr, .r_wdata, .r_rdata
  );
endmodule
